>>> rtl/hdr_pixel_rgb_scale_encoder_defines.svh
// Assertion macros for the HDR pixel scale encoder.
// Used by the RTL top hdr_pixel_rgb_scale_encoder under rtl/; no other dependencies.
`ifndef HDR_PIXEL_RGB_SCALE_ENCODER_DEFINES_SVH
`define HDR_PIXEL_RGB_SCALE_ENCODER_DEFINES_SVH
`ifndef SYNTH
`define HDRSE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HDRSE_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define HDRSE_ASSERT(lbl, clk, rstn, prop, msg)
`define HDRSE_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/hdrse_pkg.sv
// Shared types and constants of the HDR pixel scale encoder.
// No dependencies.
`timescale 1ns / 1ps
package hdrse_pkg;
    localparam int CH_W    = 16;   // channel and overbright width
    localparam int IDX_W   = 8;    // scale index width
    localparam int NUM_W   = CH_W + IDX_W;  // channel * 255, index * overbright
    localparam int OUT_W   = 16;   // fraction port width
    localparam logic [IDX_W-1:0] SCALE_MAX = 8'd255;
    localparam logic [CH_W-1:0]  OB_RESET  = 16'd512;

    // side data that rides along with the fraction divider
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             eoi;
        logic             black;
    } t_side;
endpackage

>>> rtl/hdr_pixel_rgb_scale_encoder.sv
// Top level of the HDR pixel RGB plus shared scale encoder.
// Depends on hdrse_pkg, hdrse_frac_div and the defines header.
`timescale 1ns / 1ps
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+------------------------
//  pixel in  | i_red_in i_green_in i_blue_in i_end_of_image   | start, busy (always low)
//  result    | o_red/green/blue_fraction o_scale_index ...eoi | o_valid strobe, 1 cycle
//  config    | i_overbright                                   | i_overbright_we
//
//  One beat enters per cycle; the pipeline never stalls, busy stays low.
//  The path runs through clamp/max, numerator, 8 index
//  divider steps, denominator multiply, OUT_FRAC_BITS+1 fraction divider
//  steps, saturate/output. The bit-per-stage dividers set the pipeline depth.
//  Reset is synchronous: it drops all valid bits and loads overbright = 2.0.
//  The receiver takes each result in its strobe cycle.
module hdr_pixel_rgb_scale_encoder #(
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [hdrse_pkg::CH_W-1:0]   i_red_in,
    input  logic [hdrse_pkg::CH_W-1:0]   i_green_in,
    input  logic [hdrse_pkg::CH_W-1:0]   i_blue_in,
    input  logic                         i_end_of_image,
    input  logic                         i_overbright_we,
    input  logic [hdrse_pkg::CH_W-1:0]   i_overbright,
    output logic                         o_valid,
    output logic [hdrse_pkg::OUT_W-1:0]  o_red_fraction,
    output logic [hdrse_pkg::OUT_W-1:0]  o_green_fraction,
    output logic [hdrse_pkg::OUT_W-1:0]  o_blue_fraction,
    output logic [hdrse_pkg::IDX_W-1:0]  o_scale_index,
    output logic                         o_end_of_image_out
);
    import hdrse_pkg::*;
    `include "hdr_pixel_rgb_scale_encoder_defines.svh"

    localparam int QW  = OUT_FRAC_BITS + 1;
    localparam int LAT = 4 + IDX_W + QW;
    localparam logic [NUM_W-1:0] FRAC_ONE = NUM_W'(1) << OUT_FRAC_BITS;
    localparam logic [OUT_W-1:0] FRAC_MAX =
        (FRAC_ONE > NUM_W'(16'hFFFF)) ? 16'hFFFF : FRAC_ONE[OUT_W-1:0];

    // overbright register
    logic [CH_W-1:0] r_ob;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob <= OB_RESET;
        end else if (i_overbright_we) begin
            r_ob <= i_overbright;
        end
    end

    assign busy = 1'b0;

    // stage A: clamp every channel and find the largest
    logic [CH_W-1:0] n_r, n_g, n_b, n_m;
    always_comb begin
        n_r = (i_red_in   < r_ob) ? i_red_in   : r_ob;
        n_g = (i_green_in < r_ob) ? i_green_in : r_ob;
        n_b = (i_blue_in  < r_ob) ? i_blue_in  : r_ob;
        n_m = n_r;
        if (n_g > n_m) n_m = n_g;
        if (n_b > n_m) n_m = n_b;
    end

    logic            r_a_v, r_a_eoi;
    logic [CH_W-1:0] r_a_ch [0:2];
    logic [CH_W-1:0] r_a_m, r_a_ob;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start;
        end
    end
    always_ff @(posedge i_clk) begin
        r_a_ch[0] <= n_r;
        r_a_ch[1] <= n_g;
        r_a_ch[2] <= n_b;
        r_a_m     <= n_m;
        r_a_ob    <= r_ob;
        r_a_eoi   <= i_end_of_image;
    end

    // stage B: numerator of the rounded-up index, m*255 + ob - 1
    logic [NUM_W-1:0] n_num;
    assign n_num = (NUM_W'(r_a_m) << IDX_W) - NUM_W'(r_a_m) + NUM_W'(r_a_ob) - NUM_W'(1);

    // index divider: stage 0 holds the numerator, stages 1..IDX_W one bit each
    logic             r_i_v     [0:IDX_W];
    logic [CH_W-1:0]  r_i_rem   [0:IDX_W];
    logic [IDX_W-1:0] r_i_low   [0:IDX_W];
    logic [IDX_W-1:0] r_i_q     [0:IDX_W];
    logic [CH_W-1:0]  r_i_ob    [0:IDX_W];
    logic [CH_W-1:0]  r_i_ch    [0:IDX_W][0:2];
    logic             r_i_eoi   [0:IDX_W];
    logic             r_i_black [0:IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v[0] <= 1'b0;
        end else begin
            r_i_v[0] <= r_a_v;
        end
    end
    always_ff @(posedge i_clk) begin
        r_i_rem[0]   <= n_num[NUM_W-1:IDX_W];
        r_i_low[0]   <= n_num[IDX_W-1:0];
        r_i_q[0]     <= '0;
        r_i_ob[0]    <= r_a_ob;
        r_i_ch[0]    <= r_a_ch;
        r_i_eoi[0]   <= r_a_eoi;
        r_i_black[0] <= (r_a_m == '0);
    end

    genvar s;
    generate
        for (s = 1; s <= IDX_W; s++) begin : g_idx
            logic [CH_W:0] s_t;
            assign s_t = {r_i_rem[s-1], r_i_low[s-1][IDX_W-1]};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_i_v[s] <= 1'b0;
                end else begin
                    r_i_v[s] <= r_i_v[s-1];
                end
            end
            always_ff @(posedge i_clk) begin
                // remainder stays below ob, so it fits CH_W bits
                if (s_t >= {1'b0, r_i_ob[s-1]}) begin
                    r_i_rem[s] <= CH_W'(s_t - {1'b0, r_i_ob[s-1]});
                    r_i_q[s]   <= {r_i_q[s-1][IDX_W-2:0], 1'b1};
                end else begin
                    r_i_rem[s] <= s_t[CH_W-1:0];
                    r_i_q[s]   <= {r_i_q[s-1][IDX_W-2:0], 1'b0};
                end
                r_i_low[s]   <= r_i_low[s-1] << 1;
                r_i_ob[s]    <= r_i_ob[s-1];
                r_i_ch[s]    <= r_i_ch[s-1];
                r_i_eoi[s]   <= r_i_eoi[s-1];
                r_i_black[s] <= r_i_black[s-1];
            end
        end
    endgenerate

    // stage D: denominator index*ob and numerators channel*255
    logic             r_d_v;
    logic [NUM_W-1:0] r_d_den;
    logic [NUM_W-1:0] r_d_num [0:2];
    t_side            r_d_side;
    logic [IDX_W-1:0] w_idx;
    assign w_idx = r_i_q[IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_i_v[IDX_W];
        end
    end
    always_ff @(posedge i_clk) begin
        r_d_den        <= NUM_W'(w_idx) * NUM_W'(r_i_ob[IDX_W]);
        r_d_num[0]     <= (NUM_W'(r_i_ch[IDX_W][0]) << IDX_W) - NUM_W'(r_i_ch[IDX_W][0]);
        r_d_num[1]     <= (NUM_W'(r_i_ch[IDX_W][1]) << IDX_W) - NUM_W'(r_i_ch[IDX_W][1]);
        r_d_num[2]     <= (NUM_W'(r_i_ch[IDX_W][2]) << IDX_W) - NUM_W'(r_i_ch[IDX_W][2]);
        r_d_side.idx   <= (w_idx > SCALE_MAX) ? SCALE_MAX : w_idx;
        r_d_side.eoi   <= r_i_eoi[IDX_W];
        r_d_side.black <= r_i_black[IDX_W];
    end

    // fraction divider
    logic          w_f_v;
    logic [QW-1:0] w_f_q [0:2];
    t_side         w_f_side;

    hdrse_frac_div #(
        .QW (QW)
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .i_den   (r_d_den),
        .i_num   (r_d_num),
        .i_side  (r_d_side),
        .o_valid (w_f_v),
        .o_quot  (w_f_q),
        .o_side  (w_f_side)
    );

    // output stage: saturate to the port width, zero a black pixel
    function automatic logic [OUT_W-1:0] sat_frac(input logic [QW-1:0] q, input logic black);
        logic [NUM_W-1:0] wide;
        wide = NUM_W'(q);
        if (black) begin
            sat_frac = '0;
        end else if (wide > NUM_W'(16'hFFFF)) begin
            sat_frac = 16'hFFFF;
        end else begin
            sat_frac = wide[OUT_W-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_f_v;
        end
    end
    always_ff @(posedge i_clk) begin
        o_red_fraction     <= sat_frac(w_f_q[0], w_f_side.black);
        o_green_fraction   <= sat_frac(w_f_q[1], w_f_side.black);
        o_blue_fraction    <= sat_frac(w_f_q[2], w_f_side.black);
        o_scale_index      <= w_f_side.black ? '0 : w_f_side.idx;
        o_end_of_image_out <= w_f_side.eoi;
    end

    // every accepted beat gives exactly one result strobe, and no other strobe comes out
    `HDRSE_ASSERT(a_latency, i_clk, i_rst_n, o_valid == $past(start && i_rst_n, LAT), "result strobe does not match accepted beat")
    // a zero scale index means a black pixel with zero fractions
    `HDRSE_ASSERT(a_black_zero, i_clk, i_rst_n, (o_valid && o_scale_index == '0) |-> (o_red_fraction == '0 && o_green_fraction == '0 && o_blue_fraction == '0), "black pixel with nonzero fraction")
    // fractions never exceed one
    `HDRSE_NEVER(a_frac_max, i_clk, i_rst_n, o_valid && (o_red_fraction > FRAC_MAX || o_green_fraction > FRAC_MAX || o_blue_fraction > FRAC_MAX), "fraction above one")
endmodule

>>> rtl/hdrse_frac_div.sv
// Pipelined restoring divider for the three color fractions, one quotient
// bit per stage over a shared denominator. Depends on hdrse_pkg.
`timescale 1ns / 1ps
module hdrse_frac_div #(
    parameter int QW = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [hdrse_pkg::NUM_W-1:0]    i_den,
    input  logic [hdrse_pkg::NUM_W-1:0]    i_num [0:2],
    input  hdrse_pkg::t_side               i_side,
    output logic                           o_valid,
    output logic [QW-1:0]                  o_quot [0:2],
    output hdrse_pkg::t_side               o_side
);
    import hdrse_pkg::*;

    logic               r_v    [0:QW-1];
    logic [NUM_W:0]     r_rem  [0:QW-1][0:2];
    logic [QW-1:0]      r_q    [0:QW-1][0:2];
    logic [NUM_W-1:0]   r_den  [0:QW-1];
    t_side              r_side [0:QW-1];

    genvar j, c;
    generate
        for (j = 0; j < QW; j++) begin : g_step
            logic               s_v;
            logic [NUM_W-1:0]   s_den;
            t_side              s_side;
            logic [NUM_W:0]     s_rem [0:2];
            logic [QW-1:0]      s_q   [0:2];
            if (j == 0) begin : g_first
                assign s_v    = i_valid;
                assign s_den  = i_den;
                assign s_side = i_side;
                for (c = 0; c < 3; c++) begin : g_ch
                    assign s_rem[c] = {1'b0, i_num[c]};
                    assign s_q[c]   = '0;
                end
            end else begin : g_next
                assign s_v    = r_v[j-1];
                assign s_den  = r_den[j-1];
                assign s_side = r_side[j-1];
                for (c = 0; c < 3; c++) begin : g_ch
                    // shift in a zero for the next lower quotient bit
                    assign s_rem[c] = {r_rem[j-1][c][NUM_W-1:0], 1'b0};
                    assign s_q[c]   = r_q[j-1][c];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else begin
                    r_v[j] <= s_v;
                end
            end

            for (c = 0; c < 3; c++) begin : g_div
                always_ff @(posedge i_clk) begin
                    if (s_rem[c] >= {1'b0, s_den}) begin
                        r_rem[j][c] <= s_rem[c] - {1'b0, s_den};
                        r_q[j][c]   <= s_q[c] | (QW'(1) << (QW-1-j));
                    end else begin
                        r_rem[j][c] <= s_rem[c];
                        r_q[j][c]   <= s_q[c];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_den[j]  <= s_den;
                r_side[j] <= s_side;
            end
        end
    endgenerate

    assign o_valid   = r_v[QW-1];
    assign o_side    = r_side[QW-1];
    assign o_quot[0] = r_q[QW-1][0];
    assign o_quot[1] = r_q[QW-1][1];
    assign o_quot[2] = r_q[QW-1][2];
endmodule

>>> tb/tb_hdr_pixel_rgb_scale_encoder.sv
// Testbench for the HDR pixel RGB plus shared scale encoder.
// Depends on hdrse_pkg and the RTL top hdr_pixel_rgb_scale_encoder.
`timescale 1ns / 1ps
module tb_hdr_pixel_rgb_scale_encoder;
    import hdrse_pkg::*;

    localparam int FRAC_BITS   = 15;
    localparam int DRAIN_WAIT  = 12 + FRAC_BITS + 10;
    localparam int CYCLE_LIMIT = 200000;

    // one encoded pixel as it leaves the block
    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
        logic [IDX_W-1:0] idx;
        logic             eoi;
    } t_pixel_code;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [CH_W-1:0]  i_red_in = '0;
    logic [CH_W-1:0]  i_green_in = '0;
    logic [CH_W-1:0]  i_blue_in = '0;
    logic             i_end_of_image = 1'b0;
    logic             i_overbright_we = 1'b0;
    logic [CH_W-1:0]  i_overbright = '0;
    logic             o_valid;
    logic [OUT_W-1:0] o_red_fraction;
    logic [OUT_W-1:0] o_green_fraction;
    logic [OUT_W-1:0] o_blue_fraction;
    logic [IDX_W-1:0] o_scale_index;
    logic             o_end_of_image_out;

    // shadow of the overbright register, updated with every write
    logic [CH_W-1:0] overbright_shadow = OB_RESET;
    t_pixel_code     pending_codes[$];
    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              idle_pct = 0;

    hdr_pixel_rgb_scale_encoder #(.OUT_FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_red_in(i_red_in), .i_green_in(i_green_in), .i_blue_in(i_blue_in),
        .i_end_of_image(i_end_of_image),
        .i_overbright_we(i_overbright_we), .i_overbright(i_overbright),
        .o_valid(o_valid), .o_red_fraction(o_red_fraction),
        .o_green_fraction(o_green_fraction), .o_blue_fraction(o_blue_fraction),
        .o_scale_index(o_scale_index), .o_end_of_image_out(o_end_of_image_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort on a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL hdr_pixel_rgb_scale_encoder");
            $finish;
        end
    end

    // Divide one clamped channel by index*overbright in Q1.15, saturate at 16 bits.
    function automatic logic [OUT_W-1:0] channel_fraction(logic [63:0] chan, logic [63:0] denom);
        logic [63:0] quot;
        quot = ((chan * 64'd255) << FRAC_BITS) / denom;
        return (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
    endfunction

    // Encode one pixel under the current overbright setting.
    function automatic t_pixel_code encode_pixel(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                                                 logic [CH_W-1:0] blue, logic eoi);
        t_pixel_code code;
        logic [63:0] ob, r, g, b, peak, idx;
        ob = 64'(overbright_shadow);
        r = (64'(red) < ob) ? 64'(red) : ob;
        g = (64'(green) < ob) ? 64'(green) : ob;
        b = (64'(blue) < ob) ? 64'(blue) : ob;
        peak = r;
        if (g > peak) peak = g;
        if (b > peak) peak = b;
        code = '0;
        code.eoi = eoi;
        if (peak != 0) begin
            idx = (peak * 64'd255 + ob - 64'd1) / ob;
            if (idx > 64'd255) idx = 64'd255;
            code.red = channel_fraction(r, idx * ob);
            code.green = channel_fraction(g, idx * ob);
            code.blue = channel_fraction(b, idx * ob);
            code.idx = idx[7:0];
        end
        return code;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Check each result beat against the oldest expected pixel code.
    always @(posedge i_clk) begin
        t_pixel_code want;
        if (i_rst_n && o_valid) begin
            if (pending_codes.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_codes.pop_front();
                if (o_red_fraction !== want.red)
                    report_mismatch("red", int'(o_red_fraction), int'(want.red));
                if (o_green_fraction !== want.green)
                    report_mismatch("green", int'(o_green_fraction), int'(want.green));
                if (o_blue_fraction !== want.blue)
                    report_mismatch("blue", int'(o_blue_fraction), int'(want.blue));
                if (o_scale_index !== want.idx)
                    report_mismatch("index", int'(o_scale_index), int'(want.idx));
                if (o_end_of_image_out !== want.eoi)
                    report_mismatch("eoi", int'(o_end_of_image_out), int'(want.eoi));
            end
        end
    end

    // Send one pixel beat after random idle cycles with start low; hold start until accepted.
    task automatic send_pixel(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                              logic [CH_W-1:0] blue, logic eoi);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_red_in <= red;
        i_green_in <= green;
        i_blue_in <= blue;
        i_end_of_image <= eoi;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_codes.push_back(encode_pixel(red, green, blue, eoi));
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for the pipeline to empty, then let the latency pass.
    task automatic drain_pipeline();
        stop_sending();
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_overbright(logic [CH_W-1:0] value);
        i_overbright_we <= 1'b1;
        i_overbright <= value;
        @(posedge i_clk);
        i_overbright_we <= 1'b0;
        overbright_shadow = value;
    endtask

    // Random channel: mostly below overbright, some clipped, some tiny.
    function automatic logic [CH_W-1:0] random_channel();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel == 0) return '0;
        if (sel == 1) return CH_W'($urandom_range(65535, 0));
        if (sel == 2) return CH_W'($urandom_range(3, 1));
        return CH_W'($urandom_range(overbright_shadow, 0));
    endfunction

    // Extremes, black pixels, clipping and eoi at the reset overbright.
    task automatic test_directed_corners();
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001, 1'b0);
        send_pixel(16'd512, 16'd256, 16'd128, 1'b0);
        send_pixel(16'd1, 16'd0, 16'd0, 1'b0);
        send_pixel(16'd0, 16'd2, 16'd1, 1'b1);
        send_pixel(16'd0, 16'd0, 16'd511, 1'b0);
        send_pixel(16'd513, 16'd3, 16'd0, 1'b0);
        send_pixel(16'hAAAA, 16'h5555, 16'h00FF, 1'b1);
        drain_pipeline();
    endtask

    // Extreme overbright settings; an overbright of one makes every lit pixel saturate.
    task automatic test_overbright_extremes();
        write_overbright(16'd1);
        send_pixel(16'd1, 16'd0, 16'd0, 1'b0);
        send_pixel(16'hFFFF, 16'd1, 16'd0, 1'b1);
        send_pixel(16'd0, 16'd0, 16'd0, 1'b0);
        drain_pipeline();
        write_overbright(16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_pixel(16'd1, 16'd1, 16'd1, 1'b1);
        send_pixel(16'h8000, 16'h7FFF, 16'd257, 1'b0);
        send_pixel(16'hFFFE, 16'd0, 16'd0, 1'b0);
        drain_pipeline();
        write_overbright(16'd255);
        send_pixel(16'd1, 16'd254, 16'd255, 1'b1);
        drain_pipeline();
    endtask

    // Random pixels under one overbright setting and one idling level.
    task automatic test_random_phase(logic [CH_W-1:0] ob, int pct, int count);
        write_overbright(ob);
        idle_pct = pct;
        repeat (count) send_pixel(random_channel(), random_channel(), random_channel(),
                                  1'($urandom_range(1, 0)));
        idle_pct = 0;
        drain_pipeline();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_overbright_extremes();
        test_random_phase(16'd512, 0, 150);
        test_random_phase(CH_W'($urandom_range(65535, 1)), 78, 150);
        test_random_phase(16'hFFFF, 23, 150);
        test_random_phase(16'd1, 0, 50);
        test_random_phase(CH_W'($urandom_range(4096, 2)), 78, 100);
        if (mismatch_count == 0) begin
            $display("PASS hdr_pixel_rgb_scale_encoder");
        end else begin
            $display("FAIL hdr_pixel_rgb_scale_encoder");
        end
        $finish;
    end
endmodule
